// ===== rtl/fbds_pkg.sv =====
// shared types and constants of the fractional baud divider search
// used by fbds_div, fbds_mac and fractional_baud_divider_search
package fbds_pkg;

    localparam int MUL_MAX   = 15;
    localparam int MV_W      = $clog2(MUL_MAX + 1);
    localparam int SUM_W     = MV_W + 1;
    localparam int CLK_W     = 32;
    localparam int BAUD_W    = 22;
    localparam int STEP_W    = BAUD_W + 4;
    localparam int DL_W      = 16;
    localparam int BASE_W    = STEP_W + DL_W;
    localparam int DEN_W     = BASE_W + SUM_W;
    localparam int REF_W     = CLK_W + MV_W;
    localparam int DIG_W     = 24;
    localparam int OPD_W     = 2 * DIG_W;
    localparam int ACC_W     = 2 * OPD_W;
    localparam int PROD_W    = 2 * DEN_W;
    localparam logic [CLK_W-1:0] CLOCK_RESET = 32'd12000000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_DL,
        S_MBASE,
        S_SETBASE,
        S_MDEN,
        S_NUM,
        S_MLHS,
        S_MRHS,
        S_CMP,
        S_OUT
    } state_t;

    // digit position of a partial product: 0, 1 or 2 digits up
    typedef enum logic [1:0] {
        SH_0,
        SH_1,
        SH_2
    } shift_t;

    typedef struct packed {
        logic   en;
        logic   clear;
        shift_t sh;
    } mac_ctrl_t;

endpackage

// ===== rtl/fractional_baud_divider_search.sv =====
// top level of the fractional baud divider search: sequencer and result register
// depends on fbds_pkg, fbds_div and fbds_mac
//
// One request at a time. A request with a nonzero baud rate first divides the clock
// by 16 times the baud rate, which alone settles an exact case. Otherwise the search
// scans up to 32769 divisors with 105 fraction pairs per divisor. Its run time is set
// by the single 24x24 multiply-accumulate unit: each 48 by 48 bit product takes four
// passes, and every fraction pair needs three products. The result is held in an
// output register until taken.
module fractional_baud_divider_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,     // clock_hz
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // [21:0] wanted_baud
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // [15:0] divisor_latch, [19:16] mul_value,
                                       // [23:20] div_add_value, [24] divisor_clipped
);

    localparam int DLV_W = fbds_pkg::DL_W + 1;

    fbds_pkg::state_t state_reg, state_next;

    logic [fbds_pkg::CLK_W-1:0]   clock_reg;
    logic [fbds_pkg::BAUD_W-1:0]  baud_reg, baud_next;
    logic [fbds_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [fbds_pkg::DL_W-1:0]    q_reg, q_next;
    logic [DLV_W-1:0]             dlv_reg, dlv_next;
    logic [fbds_pkg::MV_W-1:0]    mv_reg, mv_next;
    logic [fbds_pkg::MV_W-1:0]    dav_reg, dav_next;
    logic [fbds_pkg::REF_W-1:0]   ref_reg, ref_next;
    logic [fbds_pkg::BASE_W-1:0]  base_reg, base_next;
    logic [fbds_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [fbds_pkg::DEN_W-1:0]   num_reg, num_next;
    logic [fbds_pkg::DEN_W-1:0]   bnum_reg, bnum_next;
    logic [fbds_pkg::DEN_W-1:0]   bden_reg, bden_next;
    logic [fbds_pkg::PROD_W-1:0]  lhs_reg, lhs_next;
    logic                         hit_reg, hit_next;
    logic [1:0]                   k_reg, k_next;
    logic [fbds_pkg::DL_W-1:0]    dl_reg, dl_next;
    logic [fbds_pkg::MV_W-1:0]    mul_reg, mul_next;
    logic [fbds_pkg::MV_W-1:0]    add_reg, add_next;
    logic                         clip_reg, clip_next;

    logic                         div_start;
    logic                         div_busy;
    logic [fbds_pkg::CLK_W-1:0]   div_quo;
    logic                         div_rem_nz;

    fbds_pkg::mac_ctrl_t          mac_ctrl;
    logic [fbds_pkg::OPD_W-1:0]   opa, opb;
    logic [fbds_pkg::DIG_W-1:0]   a_dig, b_dig;
    logic [fbds_pkg::ACC_W-1:0]   acc;

    logic [fbds_pkg::SUM_W-1:0]   sum_md;
    logic [fbds_pkg::DEN_W-1:0]   den_acc;
    logic [fbds_pkg::DEN_W+9:0]   num1000;
    logic                         less;
    logic                         clipped;

    fbds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clock_reg),
        .divisor  (step_reg),
        .busy     (div_busy),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz)
    );

    fbds_mac u_mac (
        .clk   (clk),
        .ctrl  (mac_ctrl),
        .a_dig (a_dig),
        .b_dig (b_dig),
        .acc   (acc)
    );

    always_comb
    begin
        sum_md  = fbds_pkg::SUM_W'(mv_reg) + fbds_pkg::SUM_W'(dav_reg);
        den_acc = acc[fbds_pkg::DEN_W-1:0];
        // 1000 * num as 1024 * num - 16 * num - 8 * num
        num1000 = {num_reg, 10'b0} - {6'b0, num_reg, 4'b0} - {7'b0, num_reg, 3'b0};
        less    = lhs_reg < acc[fbds_pkg::PROD_W-1:0];
        clipped = |div_quo[fbds_pkg::CLK_W-1:fbds_pkg::DL_W];

        case (state_reg)
            fbds_pkg::S_MBASE:
            begin
                opa = fbds_pkg::OPD_W'(step_reg);
                opb = fbds_pkg::OPD_W'(dlv_reg[fbds_pkg::DL_W-1:0]);
            end
            fbds_pkg::S_MDEN:
            begin
                opa = fbds_pkg::OPD_W'(base_reg);
                opb = fbds_pkg::OPD_W'(sum_md);
            end
            fbds_pkg::S_MLHS:
            begin
                opa = fbds_pkg::OPD_W'(num_reg);
                opb = fbds_pkg::OPD_W'(bden_reg);
            end
            fbds_pkg::S_MRHS:
            begin
                opa = fbds_pkg::OPD_W'(bnum_reg);
                opb = fbds_pkg::OPD_W'(den_reg);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase

        a_dig = k_reg[1] ? opa[fbds_pkg::OPD_W-1:fbds_pkg::DIG_W] : opa[fbds_pkg::DIG_W-1:0];
        b_dig = (k_reg == 2'd1 || k_reg == 2'd3) ? opb[fbds_pkg::OPD_W-1:fbds_pkg::DIG_W]
                                                 : opb[fbds_pkg::DIG_W-1:0];
        mac_ctrl.en    = state_reg == fbds_pkg::S_MBASE || state_reg == fbds_pkg::S_MDEN ||
                         state_reg == fbds_pkg::S_MLHS  || state_reg == fbds_pkg::S_MRHS;
        mac_ctrl.clear = k_reg == 2'd0;
        case (k_reg)
            2'd0:    mac_ctrl.sh = fbds_pkg::SH_0;
            2'd3:    mac_ctrl.sh = fbds_pkg::SH_2;
            default: mac_ctrl.sh = fbds_pkg::SH_1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        baud_next  = baud_reg;
        step_next  = step_reg;
        q_next     = q_reg;
        dlv_next   = dlv_reg;
        mv_next    = mv_reg;
        dav_next   = dav_reg;
        ref_next   = ref_reg;
        base_next  = base_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        bnum_next  = bnum_reg;
        bden_next  = bden_reg;
        lhs_next   = lhs_reg;
        hit_next   = hit_reg;
        k_next     = '0;
        dl_next    = dl_reg;
        mul_next   = mul_reg;
        add_next   = add_reg;
        clip_next  = clip_reg;
        div_start  = 1'b0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        case (state_reg)
            fbds_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    baud_next = s_tdata[fbds_pkg::BAUD_W-1:0];
                    step_next = {s_tdata[fbds_pkg::BAUD_W-1:0], 4'b0};
                    dl_next   = '0;
                    mul_next  = fbds_pkg::MV_W'(1);
                    add_next  = '0;
                    clip_next = 1'b0;
                    if (s_tdata[fbds_pkg::BAUD_W-1:0] == '0)
                    begin
                        state_next = fbds_pkg::S_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = fbds_pkg::S_DIV;
                    end
                end
            end
            fbds_pkg::S_DIV:
            begin
                if (!div_busy)
                begin
                    q_next    = clipped ? '1 : div_quo[fbds_pkg::DL_W-1:0];
                    dl_next   = q_next;
                    clip_next = clipped;
                    dlv_next  = DLV_W'(q_next >> 1);
                    bnum_next = fbds_pkg::DEN_W'(baud_reg);
                    bden_next = fbds_pkg::DEN_W'(1);
                    hit_next  = 1'b0;
                    state_next = div_rem_nz ? fbds_pkg::S_DL : fbds_pkg::S_OUT;
                end
            end
            fbds_pkg::S_DL:
            begin
                if (hit_reg || dlv_reg > DLV_W'(q_reg))
                begin
                    state_next = fbds_pkg::S_OUT;
                end
                else if (dlv_reg == '0)
                begin
                    dlv_next = DLV_W'(1);
                end
                else
                begin
                    state_next = fbds_pkg::S_MBASE;
                end
            end
            fbds_pkg::S_MBASE:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    state_next = fbds_pkg::S_SETBASE;
                end
            end
            fbds_pkg::S_SETBASE:
            begin
                base_next  = acc[fbds_pkg::BASE_W-1:0];
                mv_next    = fbds_pkg::MV_W'(2);
                dav_next   = fbds_pkg::MV_W'(1);
                ref_next   = fbds_pkg::REF_W'({clock_reg, 1'b0});
                state_next = fbds_pkg::S_MDEN;
            end
            fbds_pkg::S_MDEN:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    state_next = fbds_pkg::S_NUM;
                end
            end
            fbds_pkg::S_NUM:
            begin
                den_next = den_acc;
                if (den_acc > fbds_pkg::DEN_W'(ref_reg))
                begin
                    num_next = den_acc - fbds_pkg::DEN_W'(ref_reg);
                end
                else
                begin
                    num_next = fbds_pkg::DEN_W'(ref_reg) - den_acc;
                end
                state_next = fbds_pkg::S_MLHS;
            end
            fbds_pkg::S_MLHS:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    state_next = fbds_pkg::S_MRHS;
                end
            end
            fbds_pkg::S_MRHS:
            begin
                // the left product is still in the accumulator on the first pass
                if (k_reg == 2'd0)
                begin
                    lhs_next = acc[fbds_pkg::PROD_W-1:0];
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    state_next = fbds_pkg::S_CMP;
                end
            end
            fbds_pkg::S_CMP:
            begin
                if (less)
                begin
                    dl_next   = dlv_reg[fbds_pkg::DL_W-1:0];
                    mul_next  = mv_reg;
                    add_next  = dav_reg;
                    bnum_next = num_reg;
                    bden_next = den_reg;
                    if (num1000 < (fbds_pkg::DEN_W+10)'(den_reg))
                    begin
                        hit_next = 1'b1;
                    end
                end
                if (fbds_pkg::SUM_W'(dav_reg) + 1'b1 < fbds_pkg::SUM_W'(mv_reg))
                begin
                    dav_next   = dav_reg + 1'b1;
                    state_next = fbds_pkg::S_MDEN;
                end
                else if (mv_reg < fbds_pkg::MV_W'(fbds_pkg::MUL_MAX))
                begin
                    mv_next    = mv_reg + 1'b1;
                    dav_next   = fbds_pkg::MV_W'(1);
                    ref_next   = ref_reg + fbds_pkg::REF_W'(clock_reg);
                    state_next = fbds_pkg::S_MDEN;
                end
                else
                begin
                    dlv_next   = dlv_reg + 1'b1;
                    state_next = fbds_pkg::S_DL;
                end
            end
            fbds_pkg::S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = fbds_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fbds_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbds_pkg::S_IDLE;
            clock_reg <= fbds_pkg::CLOCK_RESET;
            k_reg     <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            hit_reg   <= hit_next;
            if (cfg_we)
            begin
                clock_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        baud_reg <= baud_next;
        step_reg <= step_next;
        q_reg    <= q_next;
        dlv_reg  <= dlv_next;
        mv_reg   <= mv_next;
        dav_reg  <= dav_next;
        ref_reg  <= ref_next;
        base_reg <= base_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        bnum_reg <= bnum_next;
        bden_reg <= bden_next;
        lhs_reg  <= lhs_next;
        dl_reg   <= dl_next;
        mul_reg  <= mul_next;
        add_reg  <= add_next;
        clip_reg <= clip_next;
    end

    assign m_tdata = {7'b0, clip_reg, add_reg, mul_reg, dl_reg};

`ifndef SYNTH
    a_ready_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbds_pkg::S_CMP) |-> (mv_reg >= fbds_pkg::MV_W'(2)) && (dav_reg < mv_reg)
                                           && (dav_reg != '0))
        else $error("fraction pair out of range");

    a_result_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (mul_reg != '0) && (add_reg < mul_reg))
        else $error("result adder not below multiplier");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbds_pkg::S_CMP) |-> (den_reg != '0))
        else $error("zero candidate denominator");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy)
        else $error("divider did not start");
`endif

endmodule

// ===== rtl/fbds_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on fbds_pkg for widths
module fbds_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [fbds_pkg::CLK_W-1:0]      dividend,
    input  logic [fbds_pkg::STEP_W-1:0]     divisor,
    output logic                            busy,
    output logic [fbds_pkg::CLK_W-1:0]      quotient,
    output logic                            rem_nz
);

    localparam int CNT_W = $clog2(fbds_pkg::CLK_W);

    logic                          busy_reg, busy_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [fbds_pkg::CLK_W-1:0]    quo_reg, quo_next;
    logic [fbds_pkg::STEP_W-1:0]   rem_reg, rem_next;
    logic [fbds_pkg::STEP_W:0]     trial;
    logic                          fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[fbds_pkg::CLK_W-1]};
        fits      = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[fbds_pkg::CLK_W-2:0], fits};
            if (fits)
            begin
                rem_next = fbds_pkg::STEP_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[fbds_pkg::STEP_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(fbds_pkg::CLK_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule

// ===== rtl/fbds_mac.sv =====
// shared 24x24 multiply-accumulate unit, builds wide products digit by digit
// depends on fbds_pkg for widths and the control struct
module fbds_mac (
    input  logic                           clk,
    input  fbds_pkg::mac_ctrl_t            ctrl,
    input  logic [fbds_pkg::DIG_W-1:0]     a_dig,
    input  logic [fbds_pkg::DIG_W-1:0]     b_dig,
    output logic [fbds_pkg::ACC_W-1:0]     acc
);

    logic [fbds_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [2*fbds_pkg::DIG_W-1:0]   prod;
    logic [fbds_pkg::ACC_W-1:0]     addend;

    always_comb
    begin
        prod = a_dig * b_dig;
        case (ctrl.sh)
            fbds_pkg::SH_0: addend = fbds_pkg::ACC_W'(prod);
            fbds_pkg::SH_1: addend = fbds_pkg::ACC_W'(prod) << fbds_pkg::DIG_W;
            fbds_pkg::SH_2: addend = fbds_pkg::ACC_W'(prod) << (2 * fbds_pkg::DIG_W);
            default:        addend = '0;
        endcase
        acc_next = acc_reg;
        if (ctrl.en)
        begin
            acc_next = (ctrl.clear ? '0 : acc_reg) + addend;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
